// File: rtl/core/ahgf_pkg.sv
`timescale 1ns / 1ps
// Shared widths, the queue word type and output saturation for the geometric factor block.
package ahgf_pkg;

    localparam int W_IN   = 32;              // Q16.16 coordinate
    localparam int W_D    = W_IN + 1;        // edge difference
    localparam int W_P1   = 2 * W_D;         // product of two differences
    localparam int W_COF  = W_P1 + 1;        // cofactor
    localparam int W_P2   = W_D + W_COF;     // difference times cofactor
    localparam int W_DET  = W_P2 + 2;        // determinant, signed
    localparam int W_MAG  = W_DET - 1;       // determinant magnitude
    localparam int W_P3   = 2 * W_COF;       // cofactor times cofactor
    localparam int W_DOT  = W_P3 + 2;        // dot product of two cofactor rows
    localparam int W_NUM  = W_DOT + 1;       // rounded dividend
    localparam int W_DEN  = W_MAG + 1;       // divisor, twice the magnitude
    localparam int W_OUT  = 64;
    localparam int W_Q    = W_OUT;           // quotient bits kept before saturation
    localparam int W_CMP  = W_DEN + W_Q + 1; // shifted divisor compare width
    localparam int NG     = 6;               // number of geometric factors

    // The determinant carries 48 fraction bits; the shift by 35 leaves 13 at the output.
    localparam int J_SHIFT = 35;
    localparam int W_JQ    = W_MAG + 1 - J_SHIFT;
    localparam logic [W_MAG:0] J_HALF = (W_MAG + 1)'(1) << (J_SHIFT - 1);

    localparam logic [W_OUT-1:0] S_MAX = {1'b0, {(W_OUT - 1){1'b1}}};
    localparam logic [W_OUT-1:0] S_MIN = {1'b1, {(W_OUT - 1){1'b0}}};

    typedef logic [W_COF-1:0] t_cof;

    typedef struct packed {
        t_cof [8:0]        cof;
        logic [W_MAG-1:0]  mag;
        logic [W_OUT-1:0]  jac;
        logic              bad;
    } t_front_word;

    // Sign and magnitude to saturated two's complement.
    function automatic logic [W_OUT-1:0] sat64(input logic neg, input logic ovf,
                                               input logic [W_OUT-1:0] mag);
        logic [W_OUT-1:0] res;
        if (ovf) begin
            res = neg ? S_MIN : S_MAX;
        end else if (neg) begin
            res = (mag > S_MIN) ? S_MIN : (~mag + W_OUT'(1));
        end else begin
            res = mag[W_OUT-1] ? S_MAX : mag;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/ahgf_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for element words and factor words.
interface ahgf_elem_if import ahgf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_IN-1:0]   origin_x;
    logic [W_IN-1:0]   origin_y;
    logic [W_IN-1:0]   origin_z;
    logic [W_IN-1:0]   r_end_x;
    logic [W_IN-1:0]   r_end_y;
    logic [W_IN-1:0]   r_end_z;
    logic [W_IN-1:0]   s_end_x;
    logic [W_IN-1:0]   s_end_y;
    logic [W_IN-1:0]   s_end_z;
    logic [W_IN-1:0]   t_end_x;
    logic [W_IN-1:0]   t_end_y;
    logic [W_IN-1:0]   t_end_z;

    modport source (output valid, origin_x, origin_y, origin_z, r_end_x, r_end_y, r_end_z,
                    s_end_x, s_end_y, s_end_z, t_end_x, t_end_y, t_end_z, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, r_end_x, r_end_y, r_end_z,
                  s_end_x, s_end_y, s_end_z, t_end_x, t_end_y, t_end_z, output ready);
endinterface

interface ahgf_fac_if import ahgf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [W_OUT-1:0]  jacobian;
    logic [W_OUT-1:0]  g_rr;
    logic [W_OUT-1:0]  g_rs;
    logic [W_OUT-1:0]  g_rt;
    logic [W_OUT-1:0]  g_ss;
    logic [W_OUT-1:0]  g_st;
    logic [W_OUT-1:0]  g_tt;
    logic              bad_jacobian;

    modport source (output valid, jacobian, g_rr, g_rs, g_rt, g_ss, g_st, g_tt, bad_jacobian,
                    input ready);
    modport sink (input valid, jacobian, g_rr, g_rs, g_rt, g_ss, g_st, g_tt, bad_jacobian,
                  output ready);
endinterface

// File: rtl/core/ahgf_mul.sv
`timescale 1ns / 1ps
// Two-stage signed multiplier built from four half-width partial products.
module ahgf_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [WA-1:0]    i_a,
    input  logic signed [WB-1:0]    i_b,
    output logic signed [WA+WB-1:0] o_p
);
    localparam int LA = (WA + 1) / 2;
    localparam int HA = WA - LA;
    localparam int LB = (WB + 1) / 2;
    localparam int HB = WB - LB;
    localparam int WP = WA + WB;

    logic        [LA-1:0]    a_lo;
    logic signed [HA-1:0]    a_hi;
    logic        [LB-1:0]    b_lo;
    logic signed [HB-1:0]    b_hi;

    logic        [LA+LB-1:0]   r_ll;
    logic signed [LA+HB:0]     r_lh;
    logic signed [HA+LB:0]     r_hl;
    logic signed [HA+HB-1:0]   r_hh;
    logic signed [WP-1:0]      r_p;

    assign a_lo = i_a[LA-1:0];
    assign a_hi = i_a[WA-1:LA];
    assign b_lo = i_b[LB-1:0];
    assign b_hi = i_b[WB-1:LB];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= a_lo * b_lo;
            r_lh <= $signed({1'b0, a_lo}) * b_hi;
            r_hl <= a_hi * $signed({1'b0, b_lo});
            r_hh <= a_hi * b_hi;
            r_p  <= (WP'(r_hh) <<< (LA + LB)) + (WP'(r_hl) <<< LA)
                  + (WP'(r_lh) <<< LB) + WP'(r_ll);
        end
    end

    assign o_p = r_p;
endmodule

// File: rtl/core/ahgf_front.sv
`timescale 1ns / 1ps
// Front pipeline: edge differences, cofactors, determinant and its classification.
module ahgf_front import ahgf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ahgf_elem_if.sink    i_elem,
    input  logic         i_full,
    output logic         o_push,
    output t_front_word  o_word
);
    localparam int NV = 9;

    // Minor operands a*b - c*d, indexed as axis*3 + edge.
    localparam int MINOR_IDX [9][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    logic [NV-1:0]            r_vld;
    logic                     en;
    logic signed [W_IN-1:0]   r_org [3];
    logic signed [W_IN-1:0]   r_end [9];
    logic signed [W_D-1:0]    r_d [9];
    logic signed [W_D-1:0]    r_dr2 [3];
    logic signed [W_D-1:0]    r_dr3 [3];
    logic signed [W_D-1:0]    r_dr4 [3];
    logic signed [W_P1-1:0]   p_ab [9];
    logic signed [W_P1-1:0]   p_cd [9];
    logic signed [W_COF-1:0]  r_cof4 [9];
    logic signed [W_COF-1:0]  r_cof5 [9];
    logic signed [W_COF-1:0]  r_cof6 [9];
    logic signed [W_COF-1:0]  r_cof7 [9];
    logic signed [W_P2-1:0]   p_det [3];
    logic signed [W_DET-1:0]  r_det;
    logic [W_DET-1:0]         det_abs;
    logic [W_MAG:0]           j_round;
    logic [W_JQ-1:0]          j_quo;
    t_front_word              r_word;

    assign en           = !(r_vld[NV-1] && i_full);
    assign i_elem.ready = en;
    assign o_push       = r_vld[NV-1] && !i_full;
    assign o_word       = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_elem.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_org[0] <= i_elem.origin_x;
            r_org[1] <= i_elem.origin_y;
            r_org[2] <= i_elem.origin_z;
            r_end[0] <= i_elem.r_end_x;
            r_end[1] <= i_elem.s_end_x;
            r_end[2] <= i_elem.t_end_x;
            r_end[3] <= i_elem.r_end_y;
            r_end[4] <= i_elem.s_end_y;
            r_end[5] <= i_elem.t_end_y;
            r_end[6] <= i_elem.r_end_z;
            r_end[7] <= i_elem.s_end_z;
            r_end[8] <= i_elem.t_end_z;
            for (int k = 0; k < 9; k++) begin
                r_d[k] <= W_D'(r_end[k]) - W_D'(r_org[k / 3]);
            end
            for (int i = 0; i < 3; i++) begin
                r_dr2[i] <= r_d[3 * i];
                r_dr3[i] <= r_dr2[i];
                r_dr4[i] <= r_dr3[i];
            end
            for (int k = 0; k < 9; k++) begin
                r_cof4[k] <= W_COF'(p_ab[k]) - W_COF'(p_cd[k]);
                r_cof5[k] <= r_cof4[k];
                r_cof6[k] <= r_cof5[k];
                r_cof7[k] <= r_cof6[k];
            end
            r_det <= W_DET'(p_det[0]) + W_DET'(p_det[1]) + W_DET'(p_det[2]);
            for (int k = 0; k < 9; k++) begin
                r_word.cof[k] <= r_cof7[k];
            end
            r_word.mag <= det_abs[W_MAG-1:0];
            r_word.jac <= sat64(r_det[W_DET-1], |j_quo[W_JQ-1:W_OUT], j_quo[W_OUT-1:0]);
            r_word.bad <= r_det[W_DET-1] || (r_det == '0);
        end
    end

    for (genvar k = 0; k < 9; k++) begin : gen_minor
        ahgf_mul #(.WA(W_D), .WB(W_D)) u_mul_ab (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r_d[MINOR_IDX[k][0]]), .i_b (r_d[MINOR_IDX[k][1]]),
            .o_p   (p_ab[k])
        );
        ahgf_mul #(.WA(W_D), .WB(W_D)) u_mul_cd (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r_d[MINOR_IDX[k][2]]), .i_b (r_d[MINOR_IDX[k][3]]),
            .o_p   (p_cd[k])
        );
    end

    // Expansion of the determinant along the r column.
    for (genvar i = 0; i < 3; i++) begin : gen_det
        ahgf_mul #(.WA(W_D), .WB(W_COF)) u_mul_det (
            .i_clk (i_clk), .i_en (en),
            .i_a   (r_dr4[i]), .i_b (r_cof4[i]),
            .o_p   (p_det[i])
        );
    end

    always_comb begin
        det_abs = r_det[W_DET-1] ? W_DET'(-r_det) : W_DET'(r_det);
        j_round = {1'b0, det_abs[W_MAG-1:0]} + J_HALF;
        j_quo   = j_round[W_MAG:J_SHIFT];
    end
endmodule

// File: rtl/core/ahgf_queue.sv
`timescale 1ns / 1ps
// Short queue of classified element words between the front and back pipelines.
module ahgf_queue import ahgf_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_front_word  i_word,
    output logic         o_full,
    input  logic         i_pop,
    output t_front_word  o_word,
    output logic         o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_front_word    r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_word;
        end
    end

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt < CW'(DEPTH)))
        else $error("word written into a full queue");
    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_cnt != '0))
        else $error("word taken from an empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("queue count did not follow a write");
endmodule

// File: rtl/core/ahgf_back.sv
`timescale 1ns / 1ps
// Back pipeline: cofactor dot products, pipelined rounding division and saturation.
module ahgf_back import ahgf_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_front_word  i_word,
    input  logic         i_empty,
    output logic         o_pop,
    ahgf_fac_if.source   o_fac
);
    localparam int V_DIV0 = 5;
    localparam int V_OUT  = V_DIV0 + W_Q + 1;
    localparam int ROW_I [NG] = '{0, 0, 0, 1, 1, 2};
    localparam int ROW_J [NG] = '{0, 1, 2, 1, 2, 2};

    typedef struct packed {
        logic [W_MAG-1:0]  mag;
        logic [W_OUT-1:0]  jac;
        logic              bad;
    } t_side;

    logic [V_OUT:0]           r_vld;
    logic                     en;
    t_front_word              r_w;
    t_side                    r_s1, r_s2, r_s3;
    logic signed [W_P3-1:0]   p3 [NG][3];
    logic signed [W_DOT-1:0]  r_n [NG];
    logic [W_DOT-1:0]         n_abs [NG];
    logic [W_NUM-1:0]         r_num [NG];
    logic                     r_nneg [NG];
    logic [W_DEN-1:0]         r_den;
    t_side                    r_s4;

    logic [W_NUM-1:0]         r_rem  [W_Q+1][NG];
    logic [W_Q-1:0]           r_q    [W_Q+1][NG];
    logic                     r_ovf  [W_Q+1][NG];
    logic                     r_neg  [W_Q+1][NG];
    logic [W_DEN-1:0]         r_dden [W_Q+1];
    t_side                    r_ds   [W_Q+1];

    logic [W_OUT-1:0]         r_g [NG];
    logic [W_OUT-1:0]         r_jac;
    logic                     r_bad;

    // The output register is the last stage, so a stalled result holds the whole pipe.
    assign en    = !(r_vld[V_OUT] && !o_fac.ready);
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[V_OUT-1:0], !i_empty};
        end
    end

    for (genvar k = 0; k < NG; k++) begin : gen_dot
        for (genvar m = 0; m < 3; m++) begin : gen_term
            ahgf_mul #(.WA(W_COF), .WB(W_COF)) u_mul (
                .i_clk (i_clk), .i_en (en),
                .i_a   ($signed(r_w.cof[ROW_I[k] * 3 + m])),
                .i_b   ($signed(r_w.cof[ROW_J[k] * 3 + m])),
                .o_p   (p3[k][m])
            );
        end
    end

    always_comb begin
        for (int k = 0; k < NG; k++) begin
            n_abs[k] = r_n[k][W_DOT-1] ? W_DOT'(-r_n[k]) : W_DOT'(r_n[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w  <= i_word;
            r_s1 <= '{mag: r_w.mag, jac: r_w.jac, bad: r_w.bad};
            r_s2 <= r_s1;
            r_s3 <= r_s2;
            for (int k = 0; k < NG; k++) begin
                r_n[k] <= W_DOT'(p3[k][0]) + W_DOT'(p3[k][1]) + W_DOT'(p3[k][2]);
            end
            // Adding the magnitude before dividing by twice it rounds half away from zero.
            for (int k = 0; k < NG; k++) begin
                r_num[k]  <= W_NUM'(n_abs[k]) + W_NUM'(r_s3.mag);
                r_nneg[k] <= r_n[k][W_DOT-1];
            end
            r_den <= {r_s3.mag, 1'b0};
            r_s4  <= r_s3;
            for (int k = 0; k < NG; k++) begin
                r_rem[0][k] <= r_num[k];
                r_q[0][k]   <= '0;
                r_ovf[0][k] <= (W_CMP'(r_num[k]) >= (W_CMP'(r_den) << W_Q));
                r_neg[0][k] <= r_nneg[k];
            end
            r_dden[0] <= r_den;
            r_ds[0]   <= r_s4;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 1; s <= W_Q; s++) begin : gen_div
        localparam int B = W_Q - s;
        logic [W_CMP-1:0] shd;
        logic [W_CMP-1:0] diff [NG];
        logic             ge [NG];

        always_comb begin
            shd = W_CMP'(r_dden[s-1]) << B;
            for (int k = 0; k < NG; k++) begin
                ge[k]   = (W_CMP'(r_rem[s-1][k]) >= shd);
                diff[k] = W_CMP'(r_rem[s-1][k]) - shd;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int k = 0; k < NG; k++) begin
                    r_rem[s][k] <= ge[k] ? diff[k][W_NUM-1:0] : r_rem[s-1][k];
                    r_q[s][k]   <= r_q[s-1][k] | (W_Q'(ge[k]) << B);
                    r_ovf[s][k] <= r_ovf[s-1][k];
                    r_neg[s][k] <= r_neg[s-1][k];
                end
                r_dden[s] <= r_dden[s-1];
                r_ds[s]   <= r_ds[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NG; k++) begin
                r_g[k] <= r_ds[W_Q].bad ? '0
                        : sat64(r_neg[W_Q][k], r_ovf[W_Q][k], r_q[W_Q][k]);
            end
            r_jac <= r_ds[W_Q].jac;
            r_bad <= r_ds[W_Q].bad;
        end
    end

    assign o_fac.valid        = r_vld[V_OUT];
    assign o_fac.jacobian     = r_jac;
    assign o_fac.g_rr         = r_g[0];
    assign o_fac.g_rs         = r_g[1];
    assign o_fac.g_rt         = r_g[2];
    assign o_fac.g_ss         = r_g[3];
    assign o_fac.g_st         = r_g[4];
    assign o_fac.g_tt         = r_g[5];
    assign o_fac.bad_jacobian = r_bad;

    a_bad_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[V_OUT] && r_bad) |-> (r_g[0] == '0 && r_g[3] == '0 && r_g[5] == '0))
        else $error("factors not cleared for a bad determinant");
    a_bad_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[V_OUT] && !r_bad) |-> !r_jac[W_OUT-1])
        else $error("negative determinant without the bad flag");
endmodule

// File: rtl/core/affine_hex_geometric_factors.sv
`timescale 1ns / 1ps
// Throughput: one element per cycle while the queue is not full and the output
// is not stalled; the depth comes mostly from the 64-stage quotient pipeline,
// one bit per stage for each of the six factors.
// Reset clears only the valid bits and queue pointers; there is no clearing pass.
module affine_hex_geometric_factors import ahgf_pkg::*; #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ahgf_elem_if.sink   i_elem,
    ahgf_fac_if.source  o_fac
);
    t_front_word  push_word;
    t_front_word  pop_word;
    logic         push;
    logic         full;
    logic         pop;
    logic         empty;

    ahgf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_elem  (i_elem),
        .i_full  (full),
        .o_push  (push),
        .o_word  (push_word)
    );

    ahgf_queue #(.DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_word  (pop_word),
        .o_empty (empty)
    );

    ahgf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (pop_word),
        .i_empty (empty),
        .o_pop   (pop),
        .o_fac   (o_fac)
    );
endmodule
